// File: rtl/core/zics_pkg.sv
`timescale 1ns / 1ps

package zics_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned KEY_W  = 11;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic              is_sample;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] data;
  } item_t;

endpackage

// File: rtl/core/zics_ifs.sv
`timescale 1ns / 1ps

interface zics_req_if import zics_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [IDX_W-1:0]  entry_index;
  logic [WORD_W-1:0] cdf_value;
  logic [WORD_W-1:0] random_fraction;

  modport source (output valid, req_type, entry_index, cdf_value, random_fraction,
                  input ready);
  modport sink (input valid, req_type, entry_index, cdf_value, random_fraction,
                output ready);
endinterface

interface zics_rsp_if import zics_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_index;

  modport source (output valid, key_index, input ready);
  modport sink (input valid, key_index, output ready);
endinterface

interface zics_cfg_if import zics_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] table_size;

  modport source (output valid, table_size, input ready);
  modport sink (input valid, table_size, output ready);
endinterface

// File: rtl/core/zics_level.sv
`timescale 1ns / 1ps

module zics_level import zics_pkg::*; #(
  parameter int unsigned MAX_KEYS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  item_t                              up_item,
  input  logic [$clog2(MAX_KEYS+1)-1:0]      up_lo,
  input  logic [$clog2(MAX_KEYS+1)-1:0]      up_hi,
  output logic                               down_valid,
  input  logic                               down_ready,
  output item_t                              down_item,
  output logic [$clog2(MAX_KEYS+1)-1:0]      down_lo,
  output logic [$clog2(MAX_KEYS+1)-1:0]      down_hi
);

  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned AW = $clog2(MAX_KEYS);

  logic [WORD_W-1:0] mem [MAX_KEYS];

  logic              b_valid;
  item_t             b_item;
  logic [CW-1:0]     b_lo;
  logic [CW-1:0]     b_hi;
  logic [CW-1:0]     b_mid;
  logic [WORD_W-1:0] rdata;

  logic              c_valid;
  item_t             c_item;
  logic [CW-1:0]     c_lo;
  logic [CW-1:0]     c_hi;

  logic              ready_b;
  logic              ready_c;
  logic [CW:0]       sum;
  logic [CW-1:0]     mid;
  logic              idx_ok;
  logic [CW-1:0]     c_lo_next;
  logic [CW-1:0]     c_hi_next;

  assign ready_c  = !c_valid || down_ready;
  assign ready_b  = !b_valid || ready_c;
  assign up_ready = ready_b;

  assign sum    = {1'b0, up_lo} + {1'b0, up_hi};
  assign mid    = CW'(sum >> 1);
  assign idx_ok = 32'(up_item.idx) < 32'(MAX_KEYS);

  always_ff @(posedge clk) begin
    if (ready_b && up_valid) begin
      if (!up_item.is_sample && idx_ok) begin
        mem[AW'(up_item.idx)] <= up_item.data;
      end
      if (up_item.is_sample && (up_lo < up_hi)) begin
        rdata <= mem[AW'(mid)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (ready_b) begin
        b_valid <= up_valid;
      end
      if (ready_c) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      b_item <= up_item;
      b_lo   <= up_lo;
      b_hi   <= up_hi;
      b_mid  <= mid;
    end
    if (ready_c) begin
      c_item <= b_item;
      c_lo   <= c_lo_next;
      c_hi   <= c_hi_next;
    end
  end

  always_comb begin
    c_lo_next = b_lo;
    c_hi_next = b_hi;
    if (b_item.is_sample && (b_lo < b_hi)) begin
      if (rdata <= b_item.data) begin
        c_lo_next = b_mid + CW'(1);
      end else begin
        c_hi_next = b_mid;
      end
    end
  end

  assign down_valid = c_valid;
  assign down_item  = c_item;
  assign down_lo    = c_lo;
  assign down_hi    = c_hi;

  a_range_order: assert property (@(posedge clk) disable iff (rst)
    c_valid && c_item.is_sample |-> c_lo <= c_hi)
    else $error("search range inverted");

  a_range_shrinks: assert property (@(posedge clk) disable iff (rst)
    ready_c && b_valid && b_item.is_sample && (b_lo < b_hi)
      |=> (c_hi - c_lo) < $past(b_hi - b_lo))
    else $error("search range did not narrow");

  a_rdata_held: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_item.is_sample && (b_lo < b_hi) && !ready_c |=> $stable(rdata))
    else $error("read data lost during stall");

endmodule

// File: rtl/core/zipf_inverse_cdf_sampler.sv
`timescale 1ns / 1ps

// Inverse-CDF key sampler.
// req: one transaction per item. req_type load writes cdf_value at entry_index
//   and gives no result; req_type sample searches with random_fraction.
// rsp: one transaction per sample, key_index = first entry above the random
//   value among the first table_size entries, else table_size.
// cfg: writes table_size (saturated to MAX_KEYS); write only with no item in flight.
// Path: entry register, then the search levels, then the output register.
// Throughput: one item per cycle while rsp is not stalled. Every search level
//   owns a copy of the table with one read port; loads travel down the pipeline
//   and write each copy in order with the samples around them.
// Reset: clears all valid bits and sets table_size to 1024; table contents are
//   undefined until loaded.
// Stall: a stalled rsp holds its result; stages behind it keep filling bubbles
//   and req.ready drops only once the pipeline is full.
module zipf_inverse_cdf_sampler import zics_pkg::*; #(
  parameter int unsigned MAX_KEYS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  zics_req_if.sink   req,
  zics_rsp_if.source rsp,
  zics_cfg_if.sink   cfg
);

  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  logic [SIZE_W-1:0] table_size;
  logic [CW-1:0]     n_sat;

  logic              e_valid;
  item_t             e_item;
  logic [CW-1:0]     e_hi;

  logic              lv_valid [0:CW];
  logic              lv_ready [0:CW];
  item_t             lv_item  [0:CW];
  logic [CW-1:0]     lv_lo    [0:CW];
  logic [CW-1:0]     lv_hi    [0:CW];

  logic              o_valid;
  logic [KEY_W-1:0]  o_key;
  logic              ready_o;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg.valid) begin
      table_size <= cfg.table_size;
    end
  end

  assign n_sat = (32'(table_size) > 32'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(table_size);

  assign req.ready = !e_valid || lv_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (req.ready) begin
      e_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready) begin
      e_item.is_sample <= (req.req_type == REQ_SAMPLE);
      e_item.idx       <= req.entry_index;
      e_item.data      <= (req.req_type == REQ_SAMPLE) ? req.random_fraction : req.cdf_value;
      e_hi             <= (req.req_type == REQ_SAMPLE) ? n_sat : '0;
    end
  end

  assign lv_valid[0] = e_valid;
  assign lv_item[0]  = e_item;
  assign lv_lo[0]    = '0;
  assign lv_hi[0]    = e_hi;

  for (genvar k = 0; k < CW; k++) begin : g_level
    zics_level #(
      .MAX_KEYS(MAX_KEYS)
    ) u_level (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (lv_valid[k]),
      .up_ready  (lv_ready[k]),
      .up_item   (lv_item[k]),
      .up_lo     (lv_lo[k]),
      .up_hi     (lv_hi[k]),
      .down_valid(lv_valid[k+1]),
      .down_ready(lv_ready[k+1]),
      .down_item (lv_item[k+1]),
      .down_lo   (lv_lo[k+1]),
      .down_hi   (lv_hi[k+1])
    );
  end

  assign ready_o      = !o_valid || rsp.ready;
  assign lv_ready[CW] = ready_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (ready_o) begin
      o_valid <= lv_valid[CW] && lv_item[CW].is_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      o_key <= KEY_W'(lv_lo[CW]);
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.key_index = o_key;

  a_search_done: assert property (@(posedge clk) disable iff (rst)
    lv_valid[CW] && lv_item[CW].is_sample |-> lv_lo[CW] == lv_hi[CW])
    else $error("search not finished after last level");

  a_load_dropped: assert property (@(posedge clk) disable iff (rst)
    lv_valid[CW] && !lv_item[CW].is_sample && ready_o |=> !o_valid)
    else $error("load produced a result");

  a_key_in_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_key <= KEY_W'(n_sat))
    else $error("key beyond table size");

endmodule
